// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each helper samples on clk and is
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define AST_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define AST_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/splpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan-line palette page recorder package
// Shared constants, item types and control structs of the recorder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package splpr_pkg;

  localparam int VISIBLE_LINES = 256;
  localparam int TABLE_DEPTH   = 2 * VISIBLE_LINES;
  localparam int LINE_W        = $clog2(VISIBLE_LINES + 1);
  localparam int LINE_IDX_W    = $clog2(VISIBLE_LINES);
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int PAL_W         = 4;
  localparam int PG_W          = 8;
  localparam int ENTRY_W       = PAL_W + PG_W;
  localparam int DIV_W         = 32;
  localparam int LT_W          = 24;
  localparam int PORCH_W       = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [1:0] PENDING_SET = 2'd3;

  localparam logic [1:0] REQ_CHANGE = 2'd0;
  localparam logic [1:0] REQ_SYNC   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_PORCH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PAL   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] tick_count;
    logic [3:0]  new_palette;
    logic [7:0]  new_page;
    logic [8:0]  entry_index;
  } req_item_t;

  typedef struct packed {
    logic [8:0] scan_line;
    logic [3:0] entry_palette;
    logic [7:0] entry_page;
    logic [1:0] pending_count;
    logic       odd_half;
  } rsp_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

// ===== src/splpr_div.sv =====
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces quotient and remainder, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module splpr_div (
  input  logic                clk,
  input  logic                rst,
  input  splpr_pkg::div_req_t req,
  output splpr_pkg::div_rsp_t rsp
);
  import splpr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quot;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quot[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
        rem   <= '0;
        quot  <= req.dividend;
        dvs   <= req.divisor;
      end else if (busy) begin
        rem   <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        quot  <= {quot[DIV_W-2:0], fits};
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

// ===== src/splpr_mem.sv =====
// ----------------------------------------------------------------------------
// Line table memory
// Palette and page per line and half frame, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module splpr_mem (
  input  logic                       clk,
  input  splpr_pkg::mem_wr_t         wr,
  input  splpr_pkg::mem_rd_t         rd,
  output logic [splpr_pkg::ENTRY_W-1:0] rd_data
);
  import splpr_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== src/scanline_palette_page_recorder.sv =====
// ----------------------------------------------------------------------------
// Scan-line palette page recorder
// Tracks palette and screen page per visible line of two half frames.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel (req_valid, req_stall, req_item)
// and every request gives exactly one item on the rsp channel (rsp_valid,
// rsp_stall, rsp_item). The user must write the four registers on the cfg
// port only while the block is idle; the block does not enforce this.
// Writing the initial palette also loads the active palette. Each request
// first finds its line with one shared bit-serial divider used twice: tick
// count modulo the half-frame length, then divided by the line length. A
// change then writes the table from the last change line up to the current
// line, and a sync up to the last visible line, one entry per cycle through
// the single memory write port.
// The block takes one request at a time and holds req_stall high meanwhile.
// A finished item waits in the output register while rsp_stall is high; the
// next request is already accepted then. Reset clears the sequencer, the
// registers to their reset values and the output valid; the table itself
// is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scanline_palette_page_recorder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [splpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [splpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  splpr_pkg::req_item_t                req_item,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output splpr_pkg::rsp_item_t                rsp_item
);
  import splpr_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_DIV,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;

  logic [DIV_W-1:0]   half_frame_ticks;
  logic [LT_W-1:0]    line_ticks;
  logic [PORCH_W-1:0] top_porch_lines;
  logic [PAL_W-1:0]   active_pal;
  logic [PG_W-1:0]    active_pg;
  logic               half_sel;
  logic [LINE_W-1:0]  last_change_line;
  logic [1:0]         pending;

  req_item_t          cur_req;
  logic [LINE_W-1:0]  cur_line;
  logic [LINE_W-1:0]  fill_line;
  logic [LINE_W-1:0]  fill_end;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  logic [ENTRY_W-1:0] mem_rd_data;

  logic [DIV_W-1:0]   hf_eff;
  logic [DIV_W-1:0]   lt_eff;
  logic [DIV_W-1:0]   line_diff;
  logic [LINE_W-1:0]  line_calc;
  logic               fill_go;

  assign hf_eff = (half_frame_ticks == '0) ? DIV_W'(1) : half_frame_ticks;
  assign lt_eff = (line_ticks == '0) ? DIV_W'(1) : DIV_W'(line_ticks);

  assign req_stall = (state != S_IDLE);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = req_item.tick_count;
    div_req.divisor  = hf_eff;
    if (state == S_IDLE) begin
      div_req.start = req_valid;
    end else if (state == S_MOD) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = div_rsp.rem;
      div_req.divisor  = lt_eff;
    end
  end

  assign line_diff = div_rsp.quot - DIV_W'(top_porch_lines);

  always_comb begin
    if (div_rsp.quot < DIV_W'(top_porch_lines)) begin
      line_calc = '0;
    end else if (line_diff < DIV_W'(VISIBLE_LINES)) begin
      line_calc = line_diff[LINE_W-1:0];
    end else begin
      line_calc = LINE_W'(VISIBLE_LINES);
    end
  end

  assign fill_go      = (state == S_FILL) && (fill_line < fill_end);
  assign mem_wr.en    = fill_go;
  assign mem_wr.addr  = {fill_line[LINE_IDX_W-1:0], half_sel};
  assign mem_wr.data  = {active_pal, active_pg};
  assign mem_rd.en    = (state == S_DIV) && div_rsp.done && (cur_req.req_type == REQ_READ);
  assign mem_rd.addr  = ADDR_W'(cur_req.entry_index);

  splpr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  splpr_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      half_frame_ticks <= DIV_W'(1);
      line_ticks       <= LT_W'(1);
      top_porch_lines  <= '0;
      active_pal       <= '0;
      active_pg        <= '0;
      half_sel         <= 1'b0;
      last_change_line <= '0;
      pending          <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HALF_FRAME: half_frame_ticks <= cfg_data[DIV_W-1:0];
          CFG_LINE_TICKS: line_ticks <= cfg_data[LT_W-1:0];
          CFG_TOP_PORCH:  top_porch_lines <= cfg_data[PORCH_W-1:0];
          CFG_INIT_PAL:   active_pal <= cfg_data[PAL_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_req <= req_item;
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            cur_line  <= line_calc;
            fill_line <= last_change_line;
            case (cur_req.req_type)
              REQ_CHANGE: fill_end <= line_calc;
              REQ_SYNC:   fill_end <= LINE_W'(VISIBLE_LINES);
              default:    fill_end <= '0;
            endcase
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_go) begin
            fill_line <= fill_line + LINE_W'(1);
          end else begin
            case (cur_req.req_type)
              REQ_CHANGE: begin
                active_pal       <= cur_req.new_palette;
                active_pg        <= cur_req.new_page;
                last_change_line <= cur_line;
                pending          <= PENDING_SET;
              end
              REQ_SYNC: begin
                half_sel         <= ~half_sel;
                last_change_line <= '0;
              end
              default: ;
            endcase
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid              <= 1'b1;
            rsp_item.scan_line     <= 9'(cur_line);
            rsp_item.pending_count <= pending;
            rsp_item.odd_half      <= half_sel;
            if (cur_req.req_type == REQ_READ) begin
              rsp_item.entry_palette <= mem_rd_data[ENTRY_W-1:PG_W];
              rsp_item.entry_page    <= mem_rd_data[PG_W-1:0];
            end else begin
              rsp_item.entry_palette <= '0;
              rsp_item.entry_page    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_IMPLY(a_fill_in_range, mem_wr.en, fill_line < LINE_W'(VISIBLE_LINES), "fill beyond last line")
  `AST_IMPLY(a_line_clamped, state == S_FILL, cur_line <= LINE_W'(VISIBLE_LINES), "line not clamped")
  `AST_ALWAYS(a_pending_code, pending == 2'd0 || pending == PENDING_SET, "bad pending count")
  `AST_IMPLY(a_div_done_state, div_rsp.done, state == S_MOD || state == S_DIV, "stray divider result")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Scan-line palette page recorder testbench
// Drives change, sync, read and unused requests through the recorder under
// several register settings and flow-control mixes, predicts every result
// with a behavioral line table, and checks each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import splpr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  scanline_palette_page_recorder dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item(req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item(rsp_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register copies and recorder state of the prediction.
  logic [31:0] half_frame_len = 32'd1;
  logic [23:0] line_len = 24'd1;
  logic [5:0] porch_lines = 6'd0;
  logic [3:0] pal_rec [TABLE_DEPTH];
  logic [7:0] page_rec [TABLE_DEPTH];
  logic [3:0] cur_pal = 4'd0;
  logic [7:0] cur_page = 8'd0;
  logic cur_half = 1'b0;
  logic [8:0] mark_line = 9'd0;
  logic [1:0] redraw_left = 2'd0;

  req_item_t pending_reqs[$];
  rsp_item_t results_due[$];
  int n_taken = 0;
  int n_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int err_count = 0;
  int n_change = 0;
  int n_sync = 0;
  int n_read = 0;
  int n_unused = 0;
  int n_checked = 0;

  function automatic logic [8:0] visible_line(logic [31:0] ticks);
    logic [31:0] hf;
    logic [31:0] lt;
    logic [31:0] raw;
    hf = (half_frame_len == 32'd0) ? 32'd1 : half_frame_len;
    lt = (line_len == 24'd0) ? 32'd1 : {8'd0, line_len};
    raw = (ticks % hf) / lt;
    if (raw < {26'd0, porch_lines}) return 9'd0;
    raw = raw - {26'd0, porch_lines};
    return (raw < VISIBLE_LINES) ? raw[8:0] : 9'(VISIBLE_LINES);
  endfunction

  function automatic void fill_lines(logic [8:0] upto);
    for (logic [8:0] ln = mark_line; ln < upto && ln < 9'(VISIBLE_LINES); ln++) begin
      pal_rec[{ln[7:0], cur_half}] = cur_pal;
      page_rec[{ln[7:0], cur_half}] = cur_page;
    end
  endfunction

  function automatic rsp_item_t apply_request(req_item_t r);
    rsp_item_t y;
    logic [8:0] ln;
    y = '0;
    ln = visible_line(r.tick_count);
    case (r.req_type)
      REQ_CHANGE: begin
        fill_lines(ln);
        cur_pal = r.new_palette;
        cur_page = r.new_page;
        mark_line = ln;
        redraw_left = PENDING_SET;
      end
      REQ_SYNC: begin
        fill_lines(9'(VISIBLE_LINES));
        cur_half = ~cur_half;
        mark_line = 9'd0;
      end
      REQ_READ: begin
        y.entry_palette = pal_rec[r.entry_index];
        y.entry_page = page_rec[r.entry_index];
      end
      default: begin
      end
    endcase
    y.scan_line = ln;
    y.pending_count = redraw_left;
    y.odd_half = cur_half;
    return y;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < MAX_PRINTED)
      $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch({"mismatch on ", name}, got, want);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (n_taken == n_sent) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          req_item <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          n_sent++;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (req_valid && !req_stall) begin
        n_taken++;
        moved = 1'b1;
        results_due.push_back(apply_request(req_item));
        case (req_item.req_type)
          REQ_CHANGE: n_change++;
          REQ_SYNC: n_sync++;
          REQ_READ: n_read++;
          default: n_unused++;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected, scan_line",
                          32'(rsp_item.scan_line), 32'd0);
        end else begin
          want = results_due.pop_front();
          check_field("scan_line", 32'(rsp_item.scan_line), 32'(want.scan_line));
          check_field("entry_palette", 32'(rsp_item.entry_palette),
                      32'(want.entry_palette));
          check_field("entry_page", 32'(rsp_item.entry_page), 32'(want.entry_page));
          check_field("pending_count", 32'(rsp_item.pending_count),
                      32'(want.pending_count));
          check_field("odd_half", 32'(rsp_item.odd_half), 32'(want.odd_half));
          n_checked++;
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_HALF_FRAME: half_frame_len = data;
      CFG_LINE_TICKS: line_len = data[23:0];
      CFG_TOP_PORCH: porch_lines = data[5:0];
      CFG_INIT_PAL: cur_pal = data[3:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] hf, logic [31:0] lt, logic [31:0] porch,
                          logic [31:0] pal);
    wait_drained();
    write_reg(CFG_HALF_FRAME, hf);
    write_reg(CFG_LINE_TICKS, lt);
    write_reg(CFG_TOP_PORCH, porch);
    write_reg(CFG_INIT_PAL, pal);
  endtask

  task automatic push_req(logic [1:0] kind, logic [31:0] ticks, logic [3:0] pal,
                          logic [7:0] page, logic [8:0] idx);
    req_item_t r;
    r.req_type = kind;
    r.tick_count = ticks;
    r.new_palette = pal;
    r.new_page = page;
    r.entry_index = idx;
    pending_reqs.push_back(r);
  endtask

  task automatic run_phase(int count, int sender_idle, int receiver_stall);
    int p;
    logic [1:0] kind;
    wait_drained();
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 35) kind = REQ_CHANGE;
      else if (p < 45) kind = REQ_SYNC;
      else if (p < 95) kind = REQ_READ;
      else kind = REQ_UNUSED;
      push_req(kind, $urandom, 4'($urandom), 8'($urandom),
               9'($urandom_range(0, TABLE_DEPTH - 1)));
      if (i == count / 2) wait_drained();
    end
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two syncs first so that every table entry holds a value before any read.
    push_req(REQ_SYNC, 32'd0, 4'd0, 8'd0, 9'd0);
    push_req(REQ_SYNC, 32'hFFFF_FFFF, 4'hF, 8'hFF, 9'h1FF);
    push_req(REQ_READ, 32'd0, 4'd0, 8'd0, 9'd0);
    push_req(REQ_READ, 32'hFFFF_FFFF, 4'hF, 8'hFF, 9'h1FF);
    push_req(REQ_UNUSED, 32'hFFFF_FFFF, 4'hF, 8'hFF, 9'h1FF);

    set_regs(32'd19968, 32'd64, 32'd40, 32'd15);
    push_req(REQ_CHANGE, 32'd100, 4'hF, 8'hFF, 9'd0);
    push_req(REQ_CHANGE, 32'd8965, 4'd0, 8'd0, 9'h1FF);
    push_req(REQ_CHANGE, 32'd5760, 4'd5, 8'hA5, 9'd3);
    push_req(REQ_CHANGE, 32'd19200, 4'd9, 8'h3C, 9'd7);
    push_req(REQ_CHANGE, 32'd19968 + 32'd2880, 4'd2, 8'h81, 9'd0);
    push_req(REQ_READ, 32'd0, 4'd0, 8'd0, 9'd198);
    push_req(REQ_SYNC, 32'hFFFF_FFFF, 4'd0, 8'd0, 9'd0);
    push_req(REQ_READ, 32'd0, 4'd0, 8'd0, 9'd0);
    push_req(REQ_READ, 32'd12000, 4'd0, 8'd0, 9'd198);
    push_req(REQ_READ, 32'd12000, 4'd0, 8'd0, 9'd200);
    push_req(REQ_READ, 32'd12000, 4'd0, 8'd0, 9'd100);
    push_req(REQ_READ, 32'd12000, 4'd0, 8'd0, 9'd10);
    push_req(REQ_READ, 32'd12000, 4'd0, 8'd0, 9'h1FF);
    push_req(REQ_UNUSED, 32'd0, 4'd0, 8'd0, 9'd0);
    push_req(REQ_SYNC, 32'd3000, 4'd0, 8'd0, 9'd0);
    push_req(REQ_READ, 32'd0, 4'd0, 8'd0, 9'd1);

    set_regs(32'd19968, 32'd64, 32'd40, 32'd15);
    run_phase(200, 0, 0);
    set_regs(32'hFFFF_FFFF, 32'hFF_FFFF, 32'd63, 32'd0);
    run_phase(150, 80, 0);
    set_regs(32'd0, 32'd0, 32'd0, 32'd9);
    run_phase(100, 0, 80);
    set_regs($urandom_range(2000, 80000), $urandom_range(8, 300), $urandom_range(0, 63),
             $urandom_range(0, 15));
    run_phase(200, 10, 10);
    set_regs(32'h8000_0000, 32'h80_0000, 32'd1, 32'd6);
    run_phase(150, 0, 80);
    set_regs($urandom_range(2000, 80000), $urandom_range(8, 300), $urandom_range(0, 63),
             $urandom_range(0, 15));
    run_phase(150, 0, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Requests sent: %0d changes, %0d syncs, %0d reads, %0d unused codes;",
             n_change, n_sync, n_read, n_unused);
    $display("%0d results checked over eight register settings and four flow mixes.",
             n_checked);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
